// ===== rtl/rsbk_pkg.sv =====
// Shared types for the record sorter: transaction payloads, stored record, FSM states.
`timescale 1ns / 1ps

package rsbk_pkg;

    // One incoming student record
    typedef struct packed {
        logic [15:0] student_id;
        logic [7:0]  math_score;
        logic [7:0]  english_score;
        logic [7:0]  c_score;
        logic [9:0]  total_score;
        logic        last_record;
    } item_t;

    // One emitted record of the sorted run
    typedef struct packed {
        logic [15:0] out_id;
        logic [7:0]  out_math;
        logic [7:0]  out_english;
        logic [7:0]  out_c;
        logic [9:0]  out_total;
        logic        out_last;
        logic        overflow;
    } result_t;

    // Record as kept in the store
    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  math;
        logic [7:0]  english;
        logic [7:0]  cs;
        logic [9:0]  total;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    typedef enum logic [2:0] {
        ST_LOAD,   // collecting records of the open set
        ST_START,  // first pass: fetch entry 0
        ST_FIRST,  // entry 0 arrives into the carry register
        ST_CMP,    // one compare-and-write per cycle along the pass
        ST_WB,     // park the pass maximum at the end of the pass
        ST_EMIT    // stream the sorted run out
    } state_t;

endpackage

// ===== rtl/rsbk_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rsbk_ram #(
    parameter int WIDTH = 50,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/record_sort_by_key.sv =====
// Top level of the record sorter: load, stable in-memory bubble sort, sorted emission.
`timescale 1ns / 1ps
//
// Usage:
//   Records enter on the item channel (item_valid / item_stall / item), one per
//   cycle while a set is open. A record with last_record set closes the set.
//   Up to MAX_RECORDS records are kept; later ones are dropped and the run is
//   marked with overflow. After the closing transaction item_stall stays high
//   until the whole run has left on the sorted channel.
//   Sorting is a bubble sort over the record RAM: each pass reads one entry per
//   cycle and writes the smaller of the carried and fetched record back; the
//   pace of the sort is bounded by the single RAM read port.
//   Emission reads the RAM into an output register, fetching the next record
//   only once the current one is taken; out_last marks the final record. The
//   sorted payload holds while sorted_stall is high.
//   Reset empties the set and the output register; the RAM needs no clearing,
//   since only entries written in the current set are read.
//
module record_sort_by_key
    import rsbk_pkg::*;
#(
    parameter int MAX_RECORDS = 16
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    sorted_valid,
    input  logic    sorted_stall,
    output result_t sorted
);

    localparam int AW = $clog2(MAX_RECORDS);
    localparam int CW = $clog2(MAX_RECORDS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_RECORDS);

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            dropped_reg, dropped_next;
    logic [AW-1:0]   end_reg, end_next;
    logic [AW-1:0]   k_reg, k_next;
    rec_t            carry_reg, carry_next;
    logic [AW-1:0]   emit_reg, emit_next;
    logic            done_reg, done_next;
    logic            pend_reg, pend_next;
    logic            pend_last_reg, pend_last_next;
    logic            out_valid_reg, out_valid_next;
    result_t         out_data_reg, out_data_next;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    rec_t            ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [REC_W-1:0] ram_rdata;
    rec_t            rd_rec;
    logic [CW-1:0]   cnt_m1;
    logic [AW-1:0]   last_idx;
    logic            out_take;

    assign rd_rec   = rec_t'(ram_rdata);
    assign cnt_m1   = count_reg - CW'(1);
    assign last_idx = cnt_m1[AW-1:0];
    assign out_take = out_valid_reg && !sorted_stall;

    assign item_stall   = (state_reg != ST_LOAD);
    assign sorted_valid = out_valid_reg;
    assign sorted       = out_data_reg;

    rsbk_ram #(
        .WIDTH (REC_W),
        .DEPTH (MAX_RECORDS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            done_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            done_reg      <= done_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        end_reg       <= end_next;
        k_reg         <= k_next;
        carry_reg     <= carry_next;
        emit_reg      <= emit_next;
        pend_last_reg <= pend_last_next;
        out_data_reg  <= out_data_next;
    end

    // Next state, RAM control and output register
    always_comb
    begin
        logic [CW-1:0] cnt_after;

        state_next     = state_reg;
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        end_next       = end_reg;
        k_next         = k_reg;
        carry_next     = carry_reg;
        emit_next      = emit_reg;
        done_next      = done_reg;
        pend_next      = 1'b0;
        pend_last_next = pend_last_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = k_reg;
        ram_wdata      = carry_reg;
        ram_raddr      = '0;
        cnt_after      = count_reg;

        // output register: drain, then refill from a pending RAM read
        if (out_take)
        begin
            out_valid_next = 1'b0;
        end
        if (pend_reg)
        begin
            out_valid_next            = 1'b1;
            out_data_next.out_id      = rd_rec.id;
            out_data_next.out_math    = rd_rec.math;
            out_data_next.out_english = rd_rec.english;
            out_data_next.out_c       = rd_rec.cs;
            out_data_next.out_total   = rd_rec.total;
            out_data_next.out_last    = pend_last_reg;
            out_data_next.overflow    = dropped_reg;
        end

        case (state_reg)
            ST_LOAD:
            begin
                if (item_valid)
                begin
                    if (count_reg < MAX_CNT)
                    begin
                        ram_we            = 1'b1;
                        ram_waddr         = count_reg[AW-1:0];
                        ram_wdata.id      = item.student_id;
                        ram_wdata.math    = item.math_score;
                        ram_wdata.english = item.english_score;
                        ram_wdata.cs      = item.c_score;
                        ram_wdata.total   = item.total_score;
                        cnt_after         = count_reg + CW'(1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    count_next = cnt_after;
                    if (item.last_record)
                    begin
                        end_next  = AW'(cnt_after - CW'(1));
                        emit_next = '0;
                        done_next = 1'b0;
                        if (cnt_after > CW'(1))
                        begin
                            state_next = ST_START;
                        end
                        else
                        begin
                            state_next = ST_EMIT;
                        end
                    end
                end
            end

            ST_START:
            begin
                ram_raddr  = '0;
                state_next = ST_FIRST;
            end

            ST_FIRST:
            begin
                carry_next = rd_rec;
                ram_raddr  = AW'(1);
                k_next     = '0;
                state_next = ST_CMP;
            end

            ST_CMP:
            begin
                // strict greater-than keeps equal keys in arrival order
                ram_we    = 1'b1;
                ram_waddr = k_reg;
                if (carry_reg.math > rd_rec.math)
                begin
                    ram_wdata = rd_rec;
                end
                else
                begin
                    ram_wdata  = carry_reg;
                    carry_next = rd_rec;
                end
                if (k_reg + AW'(1) == end_reg)
                begin
                    state_next = ST_WB;
                end
                else
                begin
                    ram_raddr = k_reg + AW'(1) + AW'(1);
                    k_next    = k_reg + AW'(1);
                end
            end

            ST_WB:
            begin
                ram_we    = 1'b1;
                ram_waddr = end_reg;
                ram_wdata = carry_reg;
                if (end_reg == AW'(1))
                begin
                    emit_next  = '0;
                    done_next  = 1'b0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    end_next   = end_reg - AW'(1);
                    ram_raddr  = '0;
                    state_next = ST_FIRST;
                end
            end

            ST_EMIT:
            begin
                // fetch the next record once the output register frees up
                if (!done_reg && !pend_reg && (!out_valid_reg || out_take))
                begin
                    ram_raddr      = emit_reg;
                    pend_next      = 1'b1;
                    pend_last_next = (emit_reg == last_idx);
                    if (emit_reg == last_idx)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        emit_next = emit_reg + AW'(1);
                    end
                end
                if (out_take && out_data_reg.out_last)
                begin
                    count_next   = '0;
                    dropped_next = 1'b0;
                    state_next   = ST_LOAD;
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule
